[hw/rtl/pgpw_pkg.sv]
package pgpw_pkg;

   localparam int MAX_WIDTH_DEF     = 128;
   localparam int MAX_HEIGHT_DEF    = 64;
   localparam int GLYPH_COLUMNS_DEF = 5;
   localparam int GLYPH_ROWS_DEF    = 7;
   localparam int GLYPH_COUNT_DEF   = 128;

   localparam logic [7:0] CODE_MAX = 8'd127;

   localparam logic [1:0] REQ_FONT  = 2'd0;
   localparam logic [1:0] REQ_GAMMA = 2'd1;
   localparam logic [1:0] REQ_GLYPH = 2'd2;
   localparam logic [1:0] REQ_PIXEL = 2'd3;

   localparam int CSR_AW = 4;
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_FLIP_H = 2'd2;
   localparam logic [1:0] REG_FLIP_V = 2'd3;

   localparam logic [7:0] WIDTH_RST  = 8'd128;
   localparam logic [6:0] HEIGHT_RST = 7'd64;

   localparam int REQ_DW = 64;
   localparam int RSP_DW = 40;

   typedef struct packed {
      logic [7:0] width;
      logic [6:0] height;
      logic       flip_h;
      logic       flip_v;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic col_start;
      logic col_skip;
      logic row_next;
      logic emit_pix;
      logic emit_glyph;
      logic emit_cursor;
   } cmd_type;

   typedef struct packed {
      logic req_code_ok;
      logic col_blank;
      logic col_last;
      logic row_last;
      logic row_hit;
      logic out_free;
   } sts_type;

endpackage

[hw/rtl/pgpw_csr.sv]
module pgpw_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [pgpw_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready,
   output pgpw_pkg::cfg_type             cfg
);

   pgpw_pkg::cfg_type cfg_ff;
   pgpw_pkg::cfg_type cfg_in;
   logic              wr;

   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (csr_paddr[3:2])
            pgpw_pkg::REG_WIDTH:  cfg_in.width  = csr_pwdata[7:0];
            pgpw_pkg::REG_HEIGHT: cfg_in.height = csr_pwdata[6:0];
            pgpw_pkg::REG_FLIP_H: cfg_in.flip_h = csr_pwdata[0];
            pgpw_pkg::REG_FLIP_V: cfg_in.flip_v = csr_pwdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         pgpw_pkg::REG_WIDTH:  csr_prdata = {24'd0, cfg_ff.width};
         pgpw_pkg::REG_HEIGHT: csr_prdata = {25'd0, cfg_ff.height};
         pgpw_pkg::REG_FLIP_H: csr_prdata = {31'd0, cfg_ff.flip_h};
         pgpw_pkg::REG_FLIP_V: csr_prdata = {31'd0, cfg_ff.flip_v};
         default:              csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= pgpw_pkg::WIDTH_RST;
         cfg_ff.height <= pgpw_pkg::HEIGHT_RST;
         cfg_ff.flip_h <= 1'b0;
         cfg_ff.flip_v <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[hw/rtl/pgpw_ctrl.sv]
module pgpw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic [1:0]        req_tuser,
   output logic              req_tready,
   input  pgpw_pkg::sts_type sts,
   output pgpw_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_COL    = 3'd1;
   localparam logic [2:0] S_ROW    = 3'd2;
   localparam logic [2:0] S_PIX    = 3'd3;
   localparam logic [2:0] S_CURSOR = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               case (req_tuser)
                  pgpw_pkg::REQ_GLYPH: state_in = sts.req_code_ok ? S_COL : S_CURSOR;
                  pgpw_pkg::REQ_PIXEL: state_in = S_PIX;
                  default:             state_in = S_IDLE;
               endcase
            end
         end
         S_COL: begin
            if (sts.col_blank) begin
               cmd.col_skip = 1'b1;
               if (sts.col_last) begin
                  state_in = S_CURSOR;
               end
            end else begin
               cmd.col_start = 1'b1;
               state_in      = S_ROW;
            end
         end
         S_ROW: begin
            if (!sts.row_hit || sts.out_free) begin
               cmd.row_next   = 1'b1;
               cmd.emit_glyph = sts.row_hit;
               if (sts.row_last) begin
                  state_in = sts.col_last ? S_CURSOR : S_COL;
               end
            end
         end
         S_PIX: begin
            if (sts.out_free) begin
               cmd.emit_pix = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_CURSOR: begin
            if (sts.out_free) begin
               cmd.emit_cursor = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_one_emit: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.emit_pix, cmd.emit_glyph, cmd.emit_cursor}))
      else $error("more than one result emitted in a cycle");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_pix || cmd.emit_glyph || cmd.emit_cursor) |-> sts.out_free)
      else $error("result emitted into a full output register");

   a_bad_code: assert property (@(posedge clock) disable iff (reset)
      (cmd.capture && req_tuser == pgpw_pkg::REQ_GLYPH && !sts.req_code_ok)
      |=> state_ff == S_CURSOR)
      else $error("undrawable glyph did not go straight to cursor result");

   a_cursor_end: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_cursor |=> state_ff == S_IDLE)
      else $error("cursor result did not end the request");

endmodule

[hw/rtl/pgpw_dp.sv]
module pgpw_dp #(
   parameter int MAX_WIDTH     = pgpw_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT    = pgpw_pkg::MAX_HEIGHT_DEF,
   parameter int GLYPH_COLUMNS = pgpw_pkg::GLYPH_COLUMNS_DEF,
   parameter int GLYPH_ROWS    = pgpw_pkg::GLYPH_ROWS_DEF,
   parameter int GLYPH_COUNT   = pgpw_pkg::GLYPH_COUNT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pgpw_pkg::cfg_type           cfg,
   input  pgpw_pkg::cmd_type           cmd,
   output pgpw_pkg::sts_type           sts,
   input  logic [1:0]                  req_tuser,
   input  logic [pgpw_pkg::REQ_DW-1:0] req_tdata,
   input  logic                        rsp_tready,
   output logic                        rsp_tvalid,
   output logic                        rsp_tuser,
   output logic [pgpw_pkg::RSP_DW-1:0] rsp_tdata,
   output logic                        rsp_tlast
);

   localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_COLUMNS;
   localparam int FONT_AW    = (FONT_DEPTH > 1) ? $clog2(FONT_DEPTH) : 1;
   localparam int CW         = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;
   localparam int RW         = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;
   localparam logic [7:0] W_CLAMP = (MAX_WIDTH > 255) ? 8'd255 : 8'(MAX_WIDTH);
   localparam logic [6:0] H_CLAMP = (MAX_HEIGHT > 127) ? 7'd127 : 7'(MAX_HEIGHT);

   logic [7:0]  rq_code;
   logic [2:0]  rq_fcol;
   logic [7:0]  rq_data;
   logic [15:0] rq_x;
   logic [15:0] rq_y;
   logic [7:0]  rq_color;

   assign rq_code  = req_tdata[7:0];
   assign rq_fcol  = req_tdata[10:8];
   assign rq_data  = req_tdata[18:11];
   assign rq_x     = req_tdata[34:19];
   assign rq_y     = req_tdata[50:35];
   assign rq_color = req_tdata[58:51];

   logic [GLYPH_ROWS-1:0] font_mem [FONT_DEPTH];
   logic [7:0]            gamma_mem [256];

   logic [GLYPH_ROWS-1:0] font_q_ff;
   logic [7:0]            gamma_q_ff;
   logic [FONT_AW-1:0]    font_addr_ff, font_addr_in;
   logic [7:0]            color_ff, color_in;
   logic [16:0]           x_ff, x_in;
   logic [16:0]           y_ff, y_in;
   logic [GLYPH_ROWS-1:0] bits_ff, bits_in;
   logic [GLYPH_ROWS-1:0] prev_ff, prev_in;
   logic [CW-1:0]         col_ff, col_in;
   logic [RW-1:0]         row_ff, row_in;

   logic        ov_ff, ov_in;
   logic        o_wv_ff, o_wv_in;
   logic [12:0] o_addr_ff, o_addr_in;
   logic [7:0]  o_val_ff, o_val_in;
   logic [15:0] o_nx_ff, o_nx_in;
   logic        o_inb_ff, o_inb_in;
   logic        o_last_ff, o_last_in;

   logic [10:0]        code_base;
   logic [10:0]        font_waddr;
   logic               font_we;
   logic               gamma_we;
   logic               code_ok;
   logic [7:0]         w;
   logic [6:0]         h;
   logic [16:0]        py;
   logic               inb;
   logic [7:0]         mx;
   logic [6:0]         my;
   logic [14:0]        prod;
   logic [12:0]        addr;
   logic [16:0]        x_end;
   logic [15:0]        next_x;
   logic               out_free;

   assign code_base  = {3'd0, rq_code} * 11'(GLYPH_COLUMNS);
   assign font_waddr = code_base + {8'd0, rq_fcol};
   assign code_ok    = (rq_code <= pgpw_pkg::CODE_MAX) && ({1'b0, rq_code} < 9'(GLYPH_COUNT));
   assign font_we    = cmd.capture && (req_tuser == pgpw_pkg::REQ_FONT)
                       && ({1'b0, rq_code} < 9'(GLYPH_COUNT))
                       && ({1'b0, rq_fcol} < 4'(GLYPH_COLUMNS));
   assign gamma_we   = cmd.capture && (req_tuser == pgpw_pkg::REQ_GAMMA);

   assign w  = (cfg.width > W_CLAMP) ? W_CLAMP : cfg.width;
   assign h  = (cfg.height > H_CLAMP) ? H_CLAMP : cfg.height;
   assign py = y_ff + {{(17 - RW){1'b0}}, row_ff};

   assign inb = !x_ff[16] && (x_ff[15:0] < {8'd0, w})
                && !py[16] && (py[15:0] < {9'd0, h});
   assign mx   = cfg.flip_h ? (w - 8'd1 - x_ff[7:0]) : x_ff[7:0];
   assign my   = cfg.flip_v ? (h - 7'd1 - py[6:0]) : py[6:0];
   assign prod = {8'd0, my} * {7'd0, w};
   assign addr = prod[12:0] + {5'd0, mx};

   assign x_end  = x_ff + {16'd0, (prev_ff != '0)};
   assign next_x = (!x_end[16] && x_end[15]) ? 16'h7FFF : x_end[15:0];

   assign out_free = !ov_ff || rsp_tready;

   always_comb begin
      sts.req_code_ok = code_ok;
      sts.col_blank   = (font_q_ff == '0) && (prev_ff == '0);
      sts.col_last    = (col_ff == CW'(GLYPH_COLUMNS - 1));
      sts.row_last    = (row_ff == RW'(GLYPH_ROWS - 1));
      sts.row_hit     = bits_ff[row_ff] && inb;
      sts.out_free    = out_free;
   end

   always_comb begin
      font_addr_in = font_addr_ff;
      color_in     = color_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      bits_in      = bits_ff;
      prev_in      = prev_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      if (cmd.capture) begin
         color_in = rq_color;
         x_in     = {rq_x[15], rq_x};
         y_in     = {rq_y[15], rq_y};
         prev_in  = '0;
         col_in   = '0;
         row_in   = '0;
         if (code_ok) begin
            font_addr_in = code_base[FONT_AW-1:0];
         end
      end
      if ((cmd.col_start || cmd.col_skip) && !sts.col_last) begin
         font_addr_in = font_addr_ff + FONT_AW'(1);
      end
      if (cmd.col_skip) begin
         col_in = col_ff + CW'(1);
      end
      if (cmd.col_start) begin
         bits_in = font_q_ff;
         prev_in = font_q_ff;
         row_in  = '0;
      end
      if (cmd.row_next) begin
         row_in = row_ff + RW'(1);
         if (sts.row_last) begin
            row_in = '0;
            x_in   = x_ff + 17'd1;
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_comb begin
      ov_in     = ov_ff && !rsp_tready;
      o_wv_in   = o_wv_ff;
      o_addr_in = o_addr_ff;
      o_val_in  = o_val_ff;
      o_nx_in   = o_nx_ff;
      o_inb_in  = o_inb_ff;
      o_last_in = o_last_ff;
      if (cmd.emit_pix) begin
         ov_in     = 1'b1;
         o_wv_in   = inb;
         o_addr_in = inb ? addr : 13'd0;
         o_val_in  = inb ? gamma_q_ff : 8'd0;
         o_nx_in   = 16'd0;
         o_inb_in  = inb;
         o_last_in = 1'b1;
      end else if (cmd.emit_glyph) begin
         ov_in     = 1'b1;
         o_wv_in   = 1'b1;
         o_addr_in = addr;
         o_val_in  = gamma_q_ff;
         o_nx_in   = 16'd0;
         o_inb_in  = 1'b1;
         o_last_in = 1'b0;
      end else if (cmd.emit_cursor) begin
         ov_in     = 1'b1;
         o_wv_in   = 1'b0;
         o_addr_in = 13'd0;
         o_val_in  = 8'd0;
         o_nx_in   = next_x;
         o_inb_in  = 1'b0;
         o_last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (font_we) begin
         font_mem[font_waddr[FONT_AW-1:0]] <= rq_data[GLYPH_ROWS-1:0];
      end
      font_q_ff <= font_mem[font_addr_in];
   end

   always_ff @(posedge clock) begin
      if (gamma_we) begin
         gamma_mem[rq_code] <= rq_data;
      end
      gamma_q_ff <= gamma_mem[color_in];
   end

   always_ff @(posedge clock) begin
      font_addr_ff <= font_addr_in;
      color_ff     <= color_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      bits_ff      <= bits_in;
      prev_ff      <= prev_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      o_wv_ff      <= o_wv_in;
      o_addr_ff    <= o_addr_in;
      o_val_ff     <= o_val_in;
      o_nx_ff      <= o_nx_in;
      o_inb_ff     <= o_inb_in;
      o_last_ff    <= o_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tuser  = o_wv_ff;
   assign rsp_tlast  = o_last_ff;
   assign rsp_tdata  = {2'd0, o_inb_ff, o_nx_ff, o_val_ff, o_addr_ff};

endmodule

[hw/rtl/proportional_glyph_pixel_writer.sv]
// Character generator for a grey-level LED matrix. Font and gamma loads give no
// result. A pixel request gives one result once the output register is free.
// A glyph request scans its font columns in order: a blank column is skipped
// while none has been drawn yet or the last drawn one was blank; any other is
// read from the font memory and its rows tested in turn, each lit row in the
// frame giving one write result. A cursor result then ends the request; an
// undrawable code goes straight to it. Rows are tested one pixel per cycle
// unless a lit pixel waits for the single output register. A new request is
// taken only when the previous one has handed its last result to that register.
module proportional_glyph_pixel_writer #(
   parameter int MAX_WIDTH     = pgpw_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT    = pgpw_pkg::MAX_HEIGHT_DEF,
   parameter int GLYPH_COLUMNS = pgpw_pkg::GLYPH_COLUMNS_DEF,
   parameter int GLYPH_ROWS    = pgpw_pkg::GLYPH_ROWS_DEF,
   parameter int GLYPH_COUNT   = pgpw_pkg::GLYPH_COUNT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // code, font_column, table_data, pos_x, pos_y, color
   input  logic [pgpw_pkg::REQ_DW-1:0] req_tdata,
   // req_type
   input  logic [1:0]                  req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // write_addr, write_value, next_x, in_bounds
   output logic [pgpw_pkg::RSP_DW-1:0] rsp_tdata,
   // write_valid
   output logic                        rsp_tuser,
   output logic                        rsp_tlast,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [pgpw_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   pgpw_pkg::cfg_type cfg;
   pgpw_pkg::cmd_type cmd;
   pgpw_pkg::sts_type sts;

   pgpw_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pgpw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pgpw_dp #(
      .MAX_WIDTH     (MAX_WIDTH),
      .MAX_HEIGHT    (MAX_HEIGHT),
      .GLYPH_COLUMNS (GLYPH_COLUMNS),
      .GLYPH_ROWS    (GLYPH_ROWS),
      .GLYPH_COUNT   (GLYPH_COUNT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .sts        (sts),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[test/glyph_write_checker.sv]
module glyph_write_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [pgpw_pkg::REQ_DW-1:0] req_tdata,
   input  logic [1:0]                  req_tuser,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [pgpw_pkg::RSP_DW-1:0] rsp_tdata,
   input  logic                        rsp_tuser,
   input  logic                        rsp_tlast,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [pgpw_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   input  logic                        csr_pready,
   output int                          mismatches,
   output int                          pending
);

   typedef struct {
      logic        wr;
      logic [12:0] addr;
      logic [7:0]  value;
      logic [15:0] nx;
      logic        inb;
      logic        lst;
   } render_result_type;

   render_result_type owed_results[$];

   logic [6:0] font_cols [0:pgpw_pkg::GLYPH_COUNT_DEF*pgpw_pkg::GLYPH_COLUMNS_DEF-1];
   logic [7:0] gamma_lut [0:255];

   logic [7:0] cfg_width;
   logic [6:0] cfg_height;
   logic       cfg_flip_h;
   logic       cfg_flip_v;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   task automatic owe_result(input logic wr, input logic [12:0] addr, input logic [7:0] value,
                             input int nx, input logic inb, input logic lst);
      render_result_type r;
      if (nx > 32767) nx = 32767;
      if (nx < -32768) nx = -32768;
      r.wr = wr;
      r.addr = addr;
      r.value = value;
      r.nx = nx[15:0];
      r.inb = inb;
      r.lst = lst;
      owed_results.push_back(r);
   endtask

   function automatic bit frame_address(input int x, input int y, output logic [12:0] addr);
      int w;
      int h;
      w = (cfg_width > pgpw_pkg::MAX_WIDTH_DEF) ? pgpw_pkg::MAX_WIDTH_DEF : int'(cfg_width);
      h = (cfg_height > pgpw_pkg::MAX_HEIGHT_DEF) ? pgpw_pkg::MAX_HEIGHT_DEF
                                                   : int'(cfg_height);
      addr = '0;
      if (x < 0 || x >= w || y < 0 || y >= h) return 1'b0;
      if (cfg_flip_h) x = w - 1 - x;
      if (cfg_flip_v) y = h - 1 - y;
      addr = 13'((y * w + x) & 32'h1FFF);
      return 1'b1;
   endfunction

   task automatic render_request(input logic [1:0] kind,
                                 input logic [pgpw_pkg::REQ_DW-1:0] d);
      logic [7:0]  code;
      logic [2:0]  fcol;
      logic [7:0]  tdat;
      logic [7:0]  color;
      logic [12:0] addr;
      logic [6:0]  bits;
      logic [6:0]  prev;
      int          x;
      int          y;
      code  = d[7:0];
      fcol  = d[10:8];
      tdat  = d[18:11];
      x     = int'($signed(d[34:19]));
      y     = int'($signed(d[50:35]));
      color = d[58:51];
      case (kind)
         pgpw_pkg::REQ_FONT: begin
            if (code < pgpw_pkg::GLYPH_COUNT_DEF && fcol < pgpw_pkg::GLYPH_COLUMNS_DEF)
               font_cols[int'(code) * pgpw_pkg::GLYPH_COLUMNS_DEF + int'(fcol)] = tdat[6:0];
         end
         pgpw_pkg::REQ_GAMMA: begin
            gamma_lut[code] = tdat;
         end
         pgpw_pkg::REQ_PIXEL: begin
            if (frame_address(x, y, addr))
               owe_result(1'b1, addr, gamma_lut[color], 0, 1'b1, 1'b1);
            else
               owe_result(1'b0, '0, '0, 0, 1'b0, 1'b1);
         end
         default: begin
            if (code <= pgpw_pkg::CODE_MAX && code < pgpw_pkg::GLYPH_COUNT_DEF) begin
               prev = '0;
               for (int col = 0; col < pgpw_pkg::GLYPH_COLUMNS_DEF; col++) begin
                  bits = font_cols[int'(code) * pgpw_pkg::GLYPH_COLUMNS_DEF + col];
                  if (!(prev == '0 && bits == '0)) begin
                     prev = bits;
                     for (int row = 0; row < pgpw_pkg::GLYPH_ROWS_DEF; row++) begin
                        if (bits[row] && frame_address(x, y + row, addr))
                           owe_result(1'b1, addr, gamma_lut[color], 0, 1'b1, 1'b0);
                     end
                     x++;
                  end
               end
               if (prev != '0) x++;
            end
            owe_result(1'b0, '0, '0, x, 1'b0, 1'b1);
         end
      endcase
   endtask

   task automatic check_result();
      render_result_type want;
      if (owed_results.size() == 0) begin
         report_mismatch("result with nothing outstanding, addr", rsp_tdata[12:0], 0);
         return;
      end
      want = owed_results.pop_front();
      if (rsp_tuser !== want.wr)
         report_mismatch("write_valid", rsp_tuser, want.wr);
      if (rsp_tdata[12:0] !== want.addr)
         report_mismatch("write_addr", rsp_tdata[12:0], want.addr);
      if (rsp_tdata[20:13] !== want.value)
         report_mismatch("write_value", rsp_tdata[20:13], want.value);
      if (rsp_tdata[36:21] !== want.nx)
         report_mismatch("next_x", $signed(rsp_tdata[36:21]), $signed(want.nx));
      if (rsp_tdata[37] !== want.inb)
         report_mismatch("in_bounds", rsp_tdata[37], want.inb);
      if (rsp_tlast !== want.lst)
         report_mismatch("last", rsp_tlast, want.lst);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_width = pgpw_pkg::WIDTH_RST;
         cfg_height = pgpw_pkg::HEIGHT_RST;
         cfg_flip_h = 1'b0;
         cfg_flip_v = 1'b0;
         owed_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               pgpw_pkg::REG_WIDTH:  cfg_width = csr_pwdata[7:0];
               pgpw_pkg::REG_HEIGHT: cfg_height = csr_pwdata[6:0];
               pgpw_pkg::REG_FLIP_H: cfg_flip_h = csr_pwdata[0];
               pgpw_pkg::REG_FLIP_V: cfg_flip_v = csr_pwdata[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready) render_request(req_tuser, req_tdata);
      end
      pending = owed_results.size();
   end

endmodule

[test/proportional_glyph_pixel_writer_tb.sv]
module proportional_glyph_pixel_writer_tb;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_ITEMS   = 15;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [pgpw_pkg::REQ_DW-1:0] req_tdata = '0;
   logic [1:0]                  req_tuser = pgpw_pkg::REQ_FONT;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [pgpw_pkg::RSP_DW-1:0] rsp_tdata;
   logic                        rsp_tuser;
   logic                        rsp_tlast;
   logic                        csr_psel = 1'b0;
   logic                        csr_penable = 1'b0;
   logic                        csr_pwrite = 1'b0;
   logic [pgpw_pkg::CSR_AW-1:0] csr_paddr = '0;
   logic [31:0]                 csr_pwdata = '0;
   logic [31:0]                 csr_prdata;
   logic                        csr_pready;

   int mismatches;
   int pending;
   int cycles = 0;
   int requests_sent = 0;
   int stall_left = 0;
   bit steady = 1'b0;
   int cur_w = pgpw_pkg::MAX_WIDTH_DEF;
   int cur_h = pgpw_pkg::MAX_HEIGHT_DEF;
   int drawable_codes[$];
   int gamma_ready[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   proportional_glyph_pixel_writer dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   glyph_write_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .mismatches(mismatches), .pending(pending)
   );

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) return $urandom_range(1, 3);
      if (r < 18) return $urandom_range(4, 8);
      return $urandom_range(15, 30);
   endfunction

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("proportional_glyph_pixel_writer_tb: done, errors");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!steady && $urandom_range(0, 3) == 0) stall_left = gap_length();
      end
   end

   task automatic send_request(input logic [1:0] kind, input int code, input int fcol,
                               input int tdat, input int px, input int py, input int color);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {5'b0, color[7:0], py[15:0], px[15:0], tdat[7:0], fcol[2:0], code[7:0]};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      if (kind == pgpw_pkg::REQ_GAMMA) gamma_ready.push_back(code & 255);
      if (!steady && $urandom_range(0, 2) == 0) begin
         gap = gap_length();
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic load_glyph(input int code, input logic [39:0] cols);
      for (int c = 0; c < pgpw_pkg::GLYPH_COLUMNS_DEF; c++)
         send_request(pgpw_pkg::REQ_FONT, code, c, cols[8*c +: 8], $urandom, $urandom,
                      $urandom);
      drawable_codes.push_back(code);
   endtask

   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_frame(input int w, input int h, input int fh, input int fv);
      write_reg(pgpw_pkg::REG_WIDTH, w);
      write_reg(pgpw_pkg::REG_HEIGHT, h);
      write_reg(pgpw_pkg::REG_FLIP_H, fh);
      write_reg(pgpw_pkg::REG_FLIP_V, fv);
      cur_w = (w > pgpw_pkg::MAX_WIDTH_DEF) ? pgpw_pkg::MAX_WIDTH_DEF : w;
      cur_h = (h > pgpw_pkg::MAX_HEIGHT_DEF) ? pgpw_pkg::MAX_HEIGHT_DEF : h;
   endtask

   function automatic logic [39:0] random_font();
      logic [39:0] cols;
      for (int c = 0; c < 5; c++)
         cols[8*c +: 8] = ($urandom_range(0, 9) < 3) ? 8'h00 : 8'($urandom_range(1, 255));
      return cols;
   endfunction

   function automatic int pick_coord(input int span, input int margin);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return ($urandom_range(0, 1) == 0) ? -32768 : 32767 - $urandom_range(0, 1);
         default: return $urandom_range(0, span + margin + 2) - margin;
      endcase
   endfunction

   function automatic int pick_color();
      return gamma_ready[$urandom_range(0, gamma_ready.size() - 1)];
   endfunction

   task automatic random_step();
      int r;
      int code;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         load_glyph($urandom_range(0, 127), random_font());
      end else if (r < 18) begin
         send_request(pgpw_pkg::REQ_GAMMA, $urandom_range(0, 255), $urandom, $urandom,
                      $urandom, $urandom, $urandom);
      end else if (r < 23) begin
         send_request(pgpw_pkg::REQ_FONT, $urandom_range(0, 255), $urandom_range(0, 7),
                      $urandom, $urandom, $urandom, $urandom);
      end else if (r < 62) begin
         if ($urandom_range(0, 6) == 0) code = $urandom_range(128, 255);
         else code = drawable_codes[$urandom_range(0, drawable_codes.size() - 1)];
         send_request(pgpw_pkg::REQ_GLYPH, code, $urandom, $urandom,
                      pick_coord(cur_w, 6), pick_coord(cur_h, 8), pick_color());
      end else begin
         send_request(pgpw_pkg::REQ_PIXEL, $urandom, $urandom, $urandom,
                      pick_coord(cur_w, 2), pick_coord(cur_h, 2), pick_color());
      end
   endtask

   initial begin
      int goal;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      send_request(pgpw_pkg::REQ_GAMMA, 0, 0, 8'hA5, 0, 0, 0);
      send_request(pgpw_pkg::REQ_GAMMA, 255, 7, 8'hFF, -1, -1, 255);
      // leading blank, drawn column, two blanks (second one skipped), drawn column
      load_glyph(0, {8'h41, 8'h00, 8'h00, 8'hFF, 8'h00});
      load_glyph(127, 40'h0);
      load_glyph(64, {5{8'h7F}});
      send_request(pgpw_pkg::REQ_FONT, 200, 7, 8'h7F, 0, 0, 0);
      send_request(pgpw_pkg::REQ_GLYPH, 0, 0, 0, -1, -1, 255);
      send_request(pgpw_pkg::REQ_GLYPH, 127, 0, 0, 10, 10, 0);
      send_request(pgpw_pkg::REQ_GLYPH, 64, 0, 0, 32766, 60, 0);
      send_request(pgpw_pkg::REQ_GLYPH, 64, 0, 0, 124, 60, 255);
      send_request(pgpw_pkg::REQ_GLYPH, 255, 7, 255, 5, 5, 255);
      send_request(pgpw_pkg::REQ_PIXEL, 0, 0, 0, 127, 63, 255);
      send_request(pgpw_pkg::REQ_PIXEL, 0, 0, 0, -1, 0, 0);
      send_request(pgpw_pkg::REQ_PIXEL, 0, 0, 0, 128, 64, 0);
      send_request(pgpw_pkg::REQ_PIXEL, 0, 0, 0, -32768, 32767, 0);

      for (int phase = 0; phase < 7; phase++) begin
         settle();
         steady = (phase % 3 == 2);
         case (phase)
            1: set_frame(1, 1, 0, 0);
            2: set_frame(255, 127, 1, 1);
            3: set_frame(0, 12, 0, 1);
            4: set_frame(30, 0, 1, 0);
            5: set_frame($urandom_range(2, 40), $urandom_range(2, 24),
                         $urandom_range(0, 1), $urandom_range(0, 1));
            6: set_frame(128, 64, 1, 1);
            default: ;
         endcase
         goal = requests_sent + PHASE_ITEMS;
         while (requests_sent < goal) random_step();
      end

      settle();
      if (mismatches == 0)
         $display("proportional_glyph_pixel_writer_tb: done, clean");
      else
         $display("proportional_glyph_pixel_writer_tb: done, errors");
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/pgpw_pkg.sv
hw/rtl/pgpw_csr.sv
hw/rtl/pgpw_ctrl.sv
hw/rtl/pgpw_dp.sv
hw/rtl/proportional_glyph_pixel_writer.sv
test/glyph_write_checker.sv
test/proportional_glyph_pixel_writer_tb.sv
